>>> design/hrp_pkg.sv
package hrp_pkg;

    // Defaults for the top-level parameters
    localparam int OFFSET_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Width of the offset field on the result port
    localparam int OFFSET_OUT_W = 16;

    // One input beat
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } hrp_in_t;

    // One result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  byte_role;
        logic [3:0]  method_code;
        logic        minor_version;
        logic [OFFSET_OUT_W-1:0] byte_offset;
    } hrp_out_t;

    // Classified beat handed from the front end to the parser
    typedef struct packed {
        logic       restart;
        logic [7:0] ch;        // raw byte
        logic [7:0] lc;        // byte folded to lower case
        logic       cr;
        logic       lf;
        logic       sp;
        logic       upper;
        logic       lower;
        logic       alpha;
        logic       digit;
        logic       bin_digit; // '0' or '1'
        logic       host_ok;   // a-z 0-9 - .
        logic       qdelim;    // ? & = #
        logic       colon;
        logic       slash;
        logic       dash;
    } hrp_beat_t;

    typedef enum logic [4:0] {
        ST_START,
        ST_METHOD,
        ST_SP_METHOD,
        ST_SCHEMA,
        ST_SLASH1,
        ST_SLASH2,
        ST_HOST,
        ST_PORT,
        ST_PATH,
        ST_QUERY,
        ST_VSTART,
        ST_V_H,
        ST_V_HT,
        ST_V_HTT,
        ST_V_HTTP,
        ST_V_SLASH,
        ST_V_MAJOR,
        ST_V_DOT,
        ST_V_MINOR,
        ST_RL_CR,
        ST_HDR_START,
        ST_NAME,
        ST_COLON,
        ST_SP_COLON,
        ST_VAL,
        ST_HDR_CR,
        ST_END_CR,
        ST_BODY,
        ST_ERROR
    } hrp_state_t;

    // Status codes
    localparam logic [2:0] STAT_CONT      = 3'd0;
    localparam logic [2:0] STAT_RL_DONE   = 3'd1;
    localparam logic [2:0] STAT_HDR_DONE  = 3'd2;
    localparam logic [2:0] STAT_HDRS_DONE = 3'd3;
    localparam logic [2:0] STAT_ERROR     = 3'd4;

    // Byte roles
    localparam logic [3:0] ROLE_OTHER   = 4'd0;
    localparam logic [3:0] ROLE_METHOD  = 4'd1;
    localparam logic [3:0] ROLE_SCHEMA  = 4'd2;
    localparam logic [3:0] ROLE_HOST    = 4'd3;
    localparam logic [3:0] ROLE_PORT    = 4'd4;
    localparam logic [3:0] ROLE_PATH    = 4'd5;
    localparam logic [3:0] ROLE_QUERY   = 4'd6;
    localparam logic [3:0] ROLE_VERSION = 4'd7;
    localparam logic [3:0] ROLE_NAME    = 4'd8;
    localparam logic [3:0] ROLE_VALUE   = 4'd9;
    localparam logic [3:0] ROLE_BODY    = 4'd10;

    localparam logic [3:0] METHOD_UNKNOWN = 4'd0;

    // Characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam int METHOD_COUNT = 8;
    localparam logic [3:0] METHOD_MAX_LEN = 4'd8;

    // Method names, lower case, left aligned, zero padded
    localparam logic [63:0] METHOD_NAMES [METHOD_COUNT] = '{
        {"get",     40'd0},
        {"put",     40'd0},
        {"head",    32'd0},
        {"post",    32'd0},
        {"delete",  16'd0},
        {"trace",   24'd0},
        {"options",  8'd0},
        {"connect",  8'd0}
    };

    localparam logic [3:0] METHOD_LENS [METHOD_COUNT] = '{
        4'd3, 4'd3, 4'd4, 4'd4, 4'd6, 4'd5, 4'd7, 4'd7
    };

    function automatic logic [7:0] method_char(input logic [2:0] k, input logic [2:0] pos);
        logic [63:0] row;
        row = METHOD_NAMES[k];
        return row[8 * (7 - int'(pos)) +: 8];
    endfunction

endpackage

>>> design/http_request_head_parser.sv
// Channel   Handshake           Payload   Meaning
// input     push / full         item      one request byte or a restart, per beat
// result    empty / pop         result    status, role, method, minor, offset per byte
//
// One result beat per input beat. Sustained rate is one byte per cycle while pop
// keeps the output slot free, set by the parser state register in the back end,
// which takes one classified beat a cycle. A byte is registered in the queue and
// then in the output slot. Reset (rst_n low) empties the queue and output slot and
// puts the parser at the start of a request. When pop stalls, the output slot holds
// its beat and the queue fills; full rises after QUEUE_DEPTH waiting beats.
module http_request_head_parser
    import hrp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  hrp_in_t  item,
    output logic     empty,
    input  logic     pop,
    output hrp_out_t result
);

    // Front end: byte classification, written straight into the queue
    hrp_beat_t front_beat;
    // Queue head toward the parser
    hrp_beat_t head_beat;
    logic      queue_empty;
    logic      back_take;

    hrp_front u_front (
        .item (item),
        .beat (front_beat)
    );

    // Short queue so a stall at the result side does not stop the byte source
    // at once, and vice versa
    hrp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_beat),
        .full    (full),
        .rd_en   (back_take),
        .rd_data (head_beat),
        .empty   (queue_empty)
    );

    // Back end: parser state machine, method matcher, offset counter and
    // the registered output slot
    hrp_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (head_beat),
        .beat_valid (!queue_empty),
        .beat_take  (back_take),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

>>> design/hrp_front.sv
module hrp_front
    import hrp_pkg::*;
(
    input  hrp_in_t   item,
    output hrp_beat_t beat
);

    logic [7:0] c;

    assign c = item.data_byte;

    always_comb
    begin
        beat.restart   = item.kind;
        beat.ch        = c;
        beat.upper     = (c >= 8'h41) && (c <= 8'h5A);
        beat.lower     = (c >= 8'h61) && (c <= 8'h7A);
        beat.lc        = beat.upper ? (c | CASE_BIT) : c;
        beat.alpha     = beat.upper || beat.lower;
        beat.digit     = (c >= 8'h30) && (c <= 8'h39);
        beat.bin_digit = (c == 8'h30) || (c == 8'h31);
        beat.cr        = (c == CH_CR);
        beat.lf        = (c == CH_LF);
        beat.sp        = (c == CH_SP);
        beat.colon     = (c == 8'h3A);
        beat.slash     = (c == CH_SLASH);
        beat.dash      = (c == 8'h2D);
        beat.host_ok   = beat.lower || beat.digit || beat.dash || (c == CH_DOT);
        beat.qdelim    = (c == 8'h3F) || (c == 8'h26) || (c == 8'h3D) || (c == 8'h23);
    end

endmodule

>>> design/hrp_fifo.sv
module hrp_fifo
    import hrp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  hrp_beat_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output hrp_beat_t rd_data,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hrp_beat_t        slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> design/hrp_back.sv
module hrp_back
    import hrp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  hrp_beat_t beat,
    input  logic      beat_valid,
    output logic      beat_take,
    output hrp_out_t  result,
    output logic      empty,
    input  logic      pop
);

    localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

    hrp_state_t state_reg, state_next;
    logic [METHOD_COUNT-1:0] cand_reg, cand_next;
    logic [3:0]              mlen_reg, mlen_next;
    logic [3:0]              mres_reg, mres_next;
    logic                    minor_reg, minor_next;
    logic [OFFSET_BITS-1:0]  cnt_reg, cnt_next;
    hrp_out_t                result_reg, result_next;
    logic                    valid_reg, valid_next;

    logic [2:0] status;
    logic [3:0] role;
    logic       method_step;
    logic       method_done;
    logic       minor_load;
    logic [OFFSET_OUT_W-1:0] offset_out;

    // Output slot frees when empty or being popped
    assign beat_take = beat_valid && (!valid_reg || pop);
    assign empty     = !valid_reg;
    assign result    = result_reg;

    generate
        if (OFFSET_BITS >= OFFSET_OUT_W)
        begin : g_off_trunc
            assign offset_out = cnt_reg[OFFSET_OUT_W-1:0];
        end
        else
        begin : g_off_ext
            assign offset_out = {{(OFFSET_OUT_W - OFFSET_BITS){1'b0}}, cnt_reg};
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (beat.restart)
        begin
            state_next = ST_START;
        end
        else
        begin
            unique case (state_reg)
                ST_START:
                begin
                    if (beat.cr || beat.lf)  state_next = ST_START;
                    else if (beat.upper)     state_next = ST_METHOD;
                    else                     state_next = ST_ERROR;
                end
                ST_METHOD:
                begin
                    if (beat.sp) state_next = ST_SP_METHOD;
                end
                ST_SP_METHOD:
                begin
                    if (beat.slash)      state_next = ST_PATH;
                    else if (beat.alpha) state_next = ST_SCHEMA;
                    else if (!beat.sp)   state_next = ST_ERROR;
                end
                ST_SCHEMA:
                begin
                    if (beat.colon)       state_next = ST_SLASH1;
                    else if (!beat.lower) state_next = ST_ERROR;
                end
                ST_SLASH1: state_next = beat.slash ? ST_SLASH2 : ST_ERROR;
                ST_SLASH2: state_next = beat.slash ? ST_HOST : ST_ERROR;
                ST_HOST:
                begin
                    if (beat.host_ok)    state_next = ST_HOST;
                    else if (beat.colon) state_next = ST_PORT;
                    else if (beat.slash) state_next = ST_PATH;
                    else if (beat.sp)    state_next = ST_VSTART;
                    else                 state_next = ST_ERROR;
                end
                ST_PORT:
                begin
                    if (beat.digit)      state_next = ST_PORT;
                    else if (beat.slash) state_next = ST_PATH;
                    else if (beat.sp)    state_next = ST_VSTART;
                    else                 state_next = ST_ERROR;
                end
                ST_PATH:
                begin
                    if (beat.sp)                  state_next = ST_VSTART;
                    else if (beat.qdelim)         state_next = ST_QUERY;
                    else if (beat.cr || beat.lf)  state_next = ST_ERROR;
                end
                ST_QUERY:
                begin
                    if (beat.sp)                  state_next = ST_VSTART;
                    else if (beat.cr || beat.lf)  state_next = ST_ERROR;
                end
                ST_VSTART:
                begin
                    if (beat.ch == CH_H) state_next = ST_V_H;
                    else if (!beat.sp)   state_next = ST_ERROR;
                end
                ST_V_H:     state_next = (beat.ch == CH_T)     ? ST_V_HT    : ST_ERROR;
                ST_V_HT:    state_next = (beat.ch == CH_T)     ? ST_V_HTT   : ST_ERROR;
                ST_V_HTT:   state_next = (beat.ch == CH_P)     ? ST_V_HTTP  : ST_ERROR;
                ST_V_HTTP:  state_next = (beat.ch == CH_SLASH) ? ST_V_SLASH : ST_ERROR;
                ST_V_SLASH: state_next = (beat.ch == CH_ONE)   ? ST_V_MAJOR : ST_ERROR;
                ST_V_MAJOR: state_next = (beat.ch == CH_DOT)   ? ST_V_DOT   : ST_ERROR;
                ST_V_DOT:   state_next = beat.bin_digit        ? ST_V_MINOR : ST_ERROR;
                ST_V_MINOR:
                begin
                    if (beat.cr)      state_next = ST_RL_CR;
                    else if (beat.lf) state_next = ST_HDR_START;
                    else              state_next = ST_ERROR;
                end
                ST_RL_CR: state_next = beat.lf ? ST_HDR_START : ST_ERROR;
                ST_HDR_START:
                begin
                    if (beat.cr)         state_next = ST_END_CR;
                    else if (beat.lf)    state_next = ST_BODY;
                    else if (beat.alpha) state_next = ST_NAME;
                    else                 state_next = ST_ERROR;
                end
                ST_NAME:
                begin
                    if (beat.alpha || beat.dash) state_next = ST_NAME;
                    else if (beat.colon)         state_next = ST_COLON;
                    else                         state_next = ST_ERROR;
                end
                ST_COLON:
                begin
                    if (beat.sp)                  state_next = ST_SP_COLON;
                    else if (beat.cr || beat.lf)  state_next = ST_ERROR;
                    else                          state_next = ST_VAL;
                end
                ST_SP_COLON, ST_VAL:
                begin
                    if (beat.cr)      state_next = ST_HDR_CR;
                    else if (beat.lf) state_next = ST_HDR_START;
                    else if (beat.sp && (state_reg == ST_SP_COLON)) state_next = ST_SP_COLON;
                    else              state_next = ST_VAL;
                end
                ST_HDR_CR: state_next = beat.lf ? ST_HDR_START : ST_ERROR;
                ST_END_CR: state_next = beat.lf ? ST_BODY : ST_ERROR;
                ST_BODY:   state_next = ST_BODY;
                default:   state_next = ST_ERROR;
            endcase
        end
    end

    // Per-byte outputs and side effects
    always_comb
    begin
        status      = STAT_CONT;
        role        = ROLE_OTHER;
        method_step = 1'b0;
        method_done = 1'b0;
        minor_load  = 1'b0;
        if (!beat.restart)
        begin
            unique case (state_reg)
                ST_START:
                begin
                    if (beat.upper && !beat.cr && !beat.lf)
                    begin
                        role        = ROLE_METHOD;
                        method_step = 1'b1;
                    end
                end
                ST_METHOD:
                begin
                    if (beat.sp)
                    begin
                        method_done = 1'b1;
                    end
                    else
                    begin
                        role        = ROLE_METHOD;
                        method_step = 1'b1;
                    end
                end
                ST_SP_METHOD:
                begin
                    if (beat.slash)      role = ROLE_PATH;
                    else if (beat.alpha) role = ROLE_SCHEMA;
                end
                ST_SCHEMA:
                begin
                    if (beat.lower) role = ROLE_SCHEMA;
                end
                ST_HOST:
                begin
                    if (beat.host_ok)    role = ROLE_HOST;
                    else if (beat.slash) role = ROLE_PATH;
                end
                ST_PORT:
                begin
                    if (beat.digit)      role = ROLE_PORT;
                    else if (beat.slash) role = ROLE_PATH;
                end
                ST_PATH:
                begin
                    if (!beat.sp && !beat.qdelim && !beat.cr && !beat.lf) role = ROLE_PATH;
                end
                ST_QUERY:
                begin
                    if (!beat.sp && !beat.cr && !beat.lf) role = ROLE_QUERY;
                end
                ST_VSTART:
                begin
                    if (beat.ch == CH_H) role = ROLE_VERSION;
                end
                ST_V_H, ST_V_HT, ST_V_HTT, ST_V_HTTP, ST_V_SLASH, ST_V_MAJOR:
                begin
                    role = ROLE_VERSION;
                end
                ST_V_DOT:
                begin
                    role       = ROLE_VERSION;
                    minor_load = beat.bin_digit;
                end
                ST_V_MINOR, ST_RL_CR:
                begin
                    if (beat.lf) status = STAT_RL_DONE;
                end
                ST_HDR_START:
                begin
                    if (beat.cr)         status = STAT_CONT;
                    else if (beat.lf)    status = STAT_HDRS_DONE;
                    else if (beat.alpha) role = ROLE_NAME;
                end
                ST_NAME:
                begin
                    if (beat.alpha || beat.dash) role = ROLE_NAME;
                end
                ST_COLON:
                begin
                    if (!beat.sp && !beat.cr && !beat.lf) role = ROLE_VALUE;
                end
                ST_SP_COLON, ST_VAL:
                begin
                    if (beat.cr)      status = STAT_CONT;
                    else if (beat.lf) status = STAT_HDR_DONE;
                    else if (!(beat.sp && (state_reg == ST_SP_COLON))) role = ROLE_VALUE;
                end
                ST_HDR_CR:
                begin
                    if (beat.lf) status = STAT_HDR_DONE;
                end
                ST_END_CR:
                begin
                    if (beat.lf) status = STAT_HDRS_DONE;
                end
                ST_BODY:
                begin
                    role = ROLE_BODY;
                end
                default:
                begin
                    role = ROLE_OTHER;
                end
            endcase
            if (state_next == ST_ERROR)
            begin
                status = STAT_ERROR;
                role   = ROLE_OTHER;
            end
        end
    end

    // Method match, offset counter and minor version; the matcher drops candidates that disagree at this position
    always_comb
    begin
        cand_next  = cand_reg;
        mlen_next  = mlen_reg;
        mres_next  = mres_reg;
        minor_next = minor_reg;
        cnt_next   = cnt_reg;
        if (beat.restart)
        begin
            cand_next  = '1;
            mlen_next  = '0;
            mres_next  = METHOD_UNKNOWN;
            minor_next = 1'b0;
            cnt_next   = '0;
        end
        else
        begin
            if (cnt_reg != CNT_MAX)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (method_step)
            begin
                for (int k = 0; k < METHOD_COUNT; k++)
                begin
                    if ((mlen_reg >= METHOD_LENS[k])
                        || (beat.lc != method_char(3'(k), mlen_reg[2:0])))
                    begin
                        cand_next[k] = 1'b0;
                    end
                end
                if (mlen_reg < METHOD_MAX_LEN)
                begin
                    mlen_next = mlen_reg + 1'b1;
                end
            end
            if (method_done)
            begin
                mres_next = METHOD_UNKNOWN;
                for (int k = METHOD_COUNT - 1; k >= 0; k--)
                begin
                    if (cand_reg[k] && (METHOD_LENS[k] == mlen_reg))
                    begin
                        mres_next = 4'(k + 1);
                    end
                end
            end
            if (minor_load)
            begin
                minor_next = beat.ch[0];
            end
        end
    end

    always_comb
    begin
        result_next.status        = status;
        result_next.byte_role     = role;
        result_next.method_code   = mres_next;
        result_next.minor_version = minor_next;
        result_next.byte_offset   = beat.restart ? '0 : offset_out;
        valid_next = beat_take || (valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            cand_reg  <= '1;
            mlen_reg  <= '0;
            mres_reg  <= METHOD_UNKNOWN;
            minor_reg <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (beat_take)
            begin
                state_reg <= state_next;
                cand_reg  <= cand_next;
                mlen_reg  <= mlen_next;
                mres_reg  <= mres_next;
                minor_reg <= minor_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

>>> tb/sv/http_request_head_parser_test.sv
module http_request_head_parser_test;
    import hrp_pkg::*;

    // Input beat kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Idle percentages per phase: none, sender idle, receiver stall, both
    localparam int PHASES = 4;
    localparam int SEND_IDLE [PHASES] = '{0, 62, 0, 11};
    localparam int RECV_STALL [PHASES] = '{0, 0, 62, 11};
    localparam int BEATS_PER_PHASE = 150;

    // Leave plenty of slack at the end
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP = 60;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     push = 1'b0;
    logic     full;
    hrp_in_t  item = '0;
    logic     empty;
    logic     pop = 1'b0;
    hrp_out_t result;

    http_request_head_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Method names, lower case; code is index + 1
    string verbs [8] = '{"get", "put", "head", "post", "delete", "trace", "options", "connect"};

    // Beats waiting to be pushed, results owed by the block
    hrp_in_t  pending [$];
    hrp_out_t due_results [$];
    logic [7:0] req [$];   // request under construction

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int beats_queued = 0;

    // ---------------------------------------------------------------------
    // Parser model state
    // ---------------------------------------------------------------------
    hrp_state_t parse_at;
    logic [7:0] verb_hits;
    logic [3:0] verb_len;
    logic [3:0] verb_code;
    logic       minor_seen;
    logic [OFFSET_BITS_DEF-1:0] beat_offset;

    function automatic logic is_upper(logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic logic is_lower(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_qdelim(logic [7:0] c);
        return c == "?" || c == "&" || c == "=" || c == "#";
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return is_upper(c) ? (c | CASE_BIT) : c;
    endfunction

    function automatic void restart_parser();
        parse_at = ST_START;
        verb_hits = 8'hFF;
        verb_len = '0;
        verb_code = METHOD_UNKNOWN;
        minor_seen = 1'b0;
        beat_offset = '0;
    endfunction

    // Drop every method whose name does not have this byte at this position
    function automatic void method_step(logic [7:0] c);
        for (int k = 0; k < 8; k++)
            if (verb_len >= verbs[k].len() || fold_case(c) != verbs[k][verb_len])
                verb_hits[k] = 1'b0;
        if (verb_len < METHOD_MAX_LEN)
            verb_len++;
    endfunction

    // First surviving method of exactly the length seen wins
    function automatic void method_finish();
        verb_code = METHOD_UNKNOWN;
        for (int k = 0; k < 8; k++)
            if (verb_hits[k] && verbs[k].len() == verb_len)
            begin
                verb_code = 4'(k + 1);
                break;
            end
    endfunction

    // Byte expected while walking "HTTP/1." after the H
    function automatic logic [7:0] version_char(hrp_state_t s);
        case (s)
            ST_V_H, ST_V_HT: return CH_T;
            ST_V_HTT:        return CH_P;
            ST_V_HTTP:       return CH_SLASH;
            ST_V_SLASH:      return CH_ONE;
            default:         return CH_DOT;
        endcase
    endfunction

    // Advance the model by one beat and return the result the block owes
    function automatic hrp_out_t predict_byte_result(hrp_in_t beat);
        hrp_out_t   r;
        logic [7:0] c;
        logic [2:0] st;
        logic [3:0] role;
        hrp_state_t s;
        r = '0;
        if (beat.kind == KIND_RESTART)
        begin
            restart_parser();
            return r;
        end
        c = beat.data_byte;
        st = STAT_CONT;
        role = ROLE_OTHER;
        s = parse_at;
        r.byte_offset = beat_offset[OFFSET_OUT_W-1:0];
        if (beat_offset != '1)
            beat_offset++;

        case (s)
            ST_START:
                if (c == CH_CR || c == CH_LF)
                    ;
                else if (is_upper(c))
                begin
                    method_step(c);
                    role = ROLE_METHOD;
                    s = ST_METHOD;
                end
                else
                    s = ST_ERROR;
            ST_METHOD:
                if (c == CH_SP)
                begin
                    method_finish();
                    s = ST_SP_METHOD;
                end
                else
                begin
                    method_step(c);
                    role = ROLE_METHOD;
                end
            ST_SP_METHOD:
                if (c == CH_SLASH)
                begin
                    role = ROLE_PATH;
                    s = ST_PATH;
                end
                else if (is_upper(c) || is_lower(c))
                begin
                    role = ROLE_SCHEMA;
                    s = ST_SCHEMA;
                end
                else if (c != CH_SP)
                    s = ST_ERROR;
            ST_SCHEMA:
                if (c == ":")
                    s = ST_SLASH1;
                else if (is_lower(c))
                    role = ROLE_SCHEMA;
                else
                    s = ST_ERROR;
            ST_SLASH1:
                s = (c == CH_SLASH) ? ST_SLASH2 : ST_ERROR;
            ST_SLASH2:
                s = (c == CH_SLASH) ? ST_HOST : ST_ERROR;
            ST_HOST:
                if (is_lower(c) || is_digit(c) || c == "-" || c == CH_DOT)
                    role = ROLE_HOST;
                else if (c == ":")
                    s = ST_PORT;
                else if (c == CH_SLASH)
                begin
                    role = ROLE_PATH;
                    s = ST_PATH;
                end
                else if (c == CH_SP)
                    s = ST_VSTART;
                else
                    s = ST_ERROR;
            ST_PORT:
                if (is_digit(c))
                    role = ROLE_PORT;
                else if (c == CH_SLASH)
                begin
                    role = ROLE_PATH;
                    s = ST_PATH;
                end
                else if (c == CH_SP)
                    s = ST_VSTART;
                else
                    s = ST_ERROR;
            ST_PATH:
                if (c == CH_SP)
                    s = ST_VSTART;
                else if (is_qdelim(c))
                    s = ST_QUERY;
                else if (c == CH_CR || c == CH_LF)
                    s = ST_ERROR;
                else
                    role = ROLE_PATH;
            ST_QUERY:
                if (c == CH_SP)
                    s = ST_VSTART;
                else if (c == CH_CR || c == CH_LF)
                    s = ST_ERROR;
                else
                    role = ROLE_QUERY;
            ST_VSTART:
                if (c == CH_H)
                begin
                    role = ROLE_VERSION;
                    s = ST_V_H;
                end
                else if (c != CH_SP)
                    s = ST_ERROR;
            ST_V_H, ST_V_HT, ST_V_HTT, ST_V_HTTP, ST_V_SLASH, ST_V_MAJOR:
                if (c == version_char(s))
                begin
                    role = ROLE_VERSION;
                    s = hrp_state_t'(s + 1);
                end
                else
                    s = ST_ERROR;
            ST_V_DOT:
                if (c == "0" || c == "1")
                begin
                    role = ROLE_VERSION;
                    minor_seen = c[0];
                    s = ST_V_MINOR;
                end
                else
                    s = ST_ERROR;
            ST_V_MINOR:
                if (c == CH_CR)
                    s = ST_RL_CR;
                else if (c == CH_LF)
                begin
                    st = STAT_RL_DONE;
                    s = ST_HDR_START;
                end
                else
                    s = ST_ERROR;
            ST_RL_CR:
                if (c == CH_LF)
                begin
                    st = STAT_RL_DONE;
                    s = ST_HDR_START;
                end
                else
                    s = ST_ERROR;
            ST_HDR_START:
                if (c == CH_CR)
                    s = ST_END_CR;
                else if (c == CH_LF)
                begin
                    st = STAT_HDRS_DONE;
                    s = ST_BODY;
                end
                else if (is_upper(c) || is_lower(c))
                begin
                    role = ROLE_NAME;
                    s = ST_NAME;
                end
                else
                    s = ST_ERROR;
            ST_NAME:
                if (is_upper(c) || is_lower(c) || c == "-")
                    role = ROLE_NAME;
                else if (c == ":")
                    s = ST_COLON;
                else
                    s = ST_ERROR;
            ST_COLON:
                if (c == CH_SP)
                    s = ST_SP_COLON;
                else if (c == CH_CR || c == CH_LF)
                    s = ST_ERROR;
                else
                begin
                    role = ROLE_VALUE;
                    s = ST_VAL;
                end
            ST_SP_COLON, ST_VAL:
                if (c == CH_CR)
                    s = ST_HDR_CR;
                else if (c == CH_LF)
                begin
                    st = STAT_HDR_DONE;
                    s = ST_HDR_START;
                end
                else if (c == CH_SP && s == ST_SP_COLON)
                    role = ROLE_OTHER;
                else
                begin
                    role = ROLE_VALUE;
                    s = ST_VAL;
                end
            ST_HDR_CR:
                if (c == CH_LF)
                begin
                    st = STAT_HDR_DONE;
                    s = ST_HDR_START;
                end
                else
                    s = ST_ERROR;
            ST_END_CR:
                if (c == CH_LF)
                begin
                    st = STAT_HDRS_DONE;
                    s = ST_BODY;
                end
                else
                    s = ST_ERROR;
            ST_BODY:
                role = ROLE_BODY;
            default:
                s = ST_ERROR;
        endcase

        // errors are sticky until the next restart beat
        if (s == ST_ERROR)
        begin
            st = STAT_ERROR;
            role = ROLE_OTHER;
        end
        parse_at = s;
        r.status = st;
        r.byte_role = role;
        r.method_code = verb_code;
        r.minor_version = minor_seen;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Request builder
    // ---------------------------------------------------------------------
    task automatic add_beat(logic kind, logic [7:0] b);
        hrp_in_t beat;
        beat.kind = kind;
        beat.data_byte = b;
        pending.push_back(beat);
        beats_queued++;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            req.push_back(s[i]);
    endtask

    task automatic add_line_end();
        if ($urandom_range(3) != 0)
            req.push_back(CH_CR);
        req.push_back(CH_LF);
    endtask

    task automatic add_spaces();
        repeat ($urandom_range(2, 1))
            req.push_back(CH_SP);
    endtask

    // Random byte outside a small excluded set; query bytes may be delimiters
    function automatic logic [7:0] free_byte(logic allow_delim);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_SP || b == CH_CR || b == CH_LF || (!allow_delim && is_qdelim(b)));
        return b;
    endfunction

    function automatic logic [7:0] any_letter();
        logic [7:0] b;
        b = 8'("a" + $urandom_range(25));
        return $urandom_range(1) ? (b & ~CASE_BIT) : b;
    endfunction

    // Mostly well-formed heads with random content; some broken on purpose
    task automatic queue_request();
        int pick;
        int k;
        logic [7:0] b;
        string hostset;
        req.delete();
        hostset = "abcdefghijklmnopqrstuvwxyz0123456789-.";

        repeat ($urandom_range(2))
            req.push_back($urandom_range(1) ? CH_CR : CH_LF);

        // method: a real name in mixed case, random capitals, or a name one too long
        pick = $urandom_range(11);
        if (pick < 8)
        begin
            for (int i = 0; i < verbs[pick].len(); i++)
            begin
                b = verbs[pick][i];
                if (i == 0 || $urandom_range(1))
                    b = b & ~CASE_BIT;
                req.push_back(b);
            end
        end
        else if (pick < 10)
        begin
            repeat ($urandom_range(10, 1))
                req.push_back(8'("A" + $urandom_range(25)));
        end
        else
        begin
            k = $urandom_range(7);
            for (int i = 0; i < verbs[k].len(); i++)
                req.push_back(verbs[k][i] & ~CASE_BIT);
            req.push_back(8'("A" + $urandom_range(25)));
        end
        add_spaces();

        // target: absolute form part of the time, path may be absent after host
        pick = $urandom_range(3);
        if (pick == 0)
        begin
            if ($urandom_range(1))
                add_text("http");
            else
                repeat ($urandom_range(5, 1))
                    req.push_back(8'("a" + $urandom_range(25)));
            add_text("://");
            repeat ($urandom_range(8, 1))
                req.push_back(hostset[$urandom_range(hostset.len() - 1)]);
            if ($urandom_range(1))
            begin
                req.push_back(":");
                repeat ($urandom_range(5))
                    req.push_back(8'("0" + $urandom_range(9)));
            end
        end
        if (pick != 0 || $urandom_range(2) != 0)
        begin
            req.push_back(CH_SLASH);
            repeat ($urandom_range(6))
                req.push_back(free_byte(1'b0));
            if ($urandom_range(1))
            begin
                case ($urandom_range(3))
                    0: req.push_back("?");
                    1: req.push_back("&");
                    2: req.push_back("=");
                    default: req.push_back("#");
                endcase
                repeat ($urandom_range(6))
                    req.push_back(free_byte(1'b1));
            end
        end
        add_spaces();
        add_text("HTTP/1.");
        req.push_back($urandom_range(1) ? "1" : "0");
        add_line_end();

        // header lines
        repeat ($urandom_range(3))
        begin
            req.push_back(any_letter());
            repeat ($urandom_range(6))
                req.push_back($urandom_range(4) == 0 ? "-" : any_letter());
            req.push_back(":");
            pick = $urandom_range(9);
            if (pick == 9)
                ;                   // line end right after the colon: error
            else
            begin
                if (pick != 0)
                    add_spaces();
                if (pick < 8)       // 8 leaves the value empty
                    repeat ($urandom_range(8, 1))
                        req.push_back($urandom_range(5) == 0 ? CH_SP : free_byte(1'b1));
            end
            add_line_end();
        end
        add_line_end();
        repeat ($urandom_range(4))
            req.push_back(8'($urandom_range(255)));

        // break a fifth of the heads, cut some short
        if ($urandom_range(4) == 0)
            req[$urandom_range(req.size() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(9) == 0)
            req = req[0 : $urandom_range(req.size() - 1)];

        add_beat(KIND_RESTART, 8'($urandom_range(255)));
        foreach (req[i])
            add_beat(KIND_DATA, req[i]);
    endtask

    // ---------------------------------------------------------------------
    // Mismatch reporting
    // ---------------------------------------------------------------------
    task automatic report(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("beat %0d: %s expected %0h got %0h", results_seen, what, want, got);
    endtask

    // ---------------------------------------------------------------------
    // Driver: a held beat stays on the port until taken; the model advances
    // on each accepted beat so expectations queue up in push order.
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
                due_results.push_back(predict_byte_result(item));
            if (!push || !full)
            begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item <= pending.pop_front();
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: every popped beat is matched against the oldest expectation
    // ---------------------------------------------------------------------
    hrp_out_t oldest;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (due_results.size() == 0)
                    report("result with nothing owed", 0, result);
                else
                begin
                    oldest = due_results.pop_front();
                    if (result.status !== oldest.status)
                        report("status", oldest.status, result.status);
                    if (result.byte_role !== oldest.byte_role)
                        report("byte_role", oldest.byte_role, result.byte_role);
                    if (result.method_code !== oldest.method_code)
                        report("method_code", oldest.method_code, result.method_code);
                    if (result.minor_version !== oldest.minor_version)
                        report("minor_version", oldest.minor_version, result.minor_version);
                    if (result.byte_offset !== oldest.byte_offset)
                        report("byte_offset", oldest.byte_offset, result.byte_offset);
                end
                results_seen++;
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------------
    initial
    begin
        int goal;
        restart_parser();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: byte extremes, error persistence, skipped CR/LF,
        // mixed-case method, NUL after method, unknown method, space skipping
        add_beat(KIND_RESTART, 8'hFF);
        add_beat(KIND_DATA, 8'hFF);
        add_beat(KIND_DATA, 8'h00);
        add_beat(KIND_RESTART, 8'h00);
        add_beat(KIND_DATA, CH_CR);
        add_beat(KIND_DATA, CH_LF);
        add_beat(KIND_DATA, "D");
        add_beat(KIND_DATA, "e");
        add_beat(KIND_DATA, "L");
        add_beat(KIND_DATA, "e");
        add_beat(KIND_DATA, "t");
        add_beat(KIND_DATA, "E");
        add_beat(KIND_DATA, CH_SP);
        add_beat(KIND_DATA, CH_SP);
        add_beat(KIND_DATA, 8'h00);
        add_beat(KIND_RESTART, 8'h5A);
        add_beat(KIND_DATA, "Z");
        add_beat(KIND_DATA, CH_SP);
        add_beat(KIND_DATA, CH_SLASH);
        add_beat(KIND_DATA, CH_SP);
        add_beat(KIND_DATA, CH_SP);
        add_beat(KIND_DATA, "X");
        add_beat(KIND_DATA, 8'h80);
        while (pending.size() != 0)
            @(negedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            goal = beats_queued + BEATS_PER_PHASE;
            while (beats_queued < goal)
                queue_request();
            while (pending.size() != 0)
                @(negedge clk);
        end

        while (push)
            @(negedge clk);
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
